FILE: hdl/sha256_message_hasher_core_defines.svh
// Assertion macros for the checker file of the SHA-256 core
`ifndef SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SMH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 core check failed");

// Next-cycle implication, checked while out of reset
`define SMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 core check failed");

`endif

FILE: hdl/sha_mh_pkg.sv
// Package: SHA-256 constants, round functions and control state type
package sha_mh_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CHAIN_N    = 8;
  localparam int unsigned WINDOW_N   = 16;
  localparam int unsigned ROUNDS     = 64;

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;

  localparam logic [31:0] IV_TAB [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    S_IDLE,   // taking message words
    S_PAD,    // pushing padding and length words
    S_LOAD,   // chain state -> working vars
    S_ROUND,  // 64 compression rounds
    S_ADD,    // chain state += working vars
    S_ORD,    // read one digest word
    S_OCAP,   // capture it into the output register
    S_DONE    // back to initial chain state
  } state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    ch_f = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    maj_f = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: hdl/sha_mh_if.sv
// Interfaces: message word channel and digest word channel
interface sha_mh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  word_bytes;
  logic        msg_end;

  modport source (output valid, output msg_word, output word_bytes, output msg_end,
                  input ready);
  modport sink   (input valid, input msg_word, input word_bytes, input msg_end,
                  output ready);
endinterface

interface sha_mh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_index,
                  input digest_last, output ready);
endinterface

FILE: hdl/sha_mh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module sha_mh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sha256_message_hasher_core.sv
// SHA-256 core: non-final words are taken in the idle state; every 16th pushed word adds a
// compression (chain-state reads, 64 rounds at one per cycle, then read-add-write of the chain).
// A final word adds 2 to 18 padding pushes, one or two compressions, and the digest read-out
// (a read state and a capture state per beat); output back-pressure stretches the read-out.
// The input is not ready while a block is padded, compressed or read out.
// Reset (synchronous) restores the initial hash values through per-entry valid bits.
module sha256_message_hasher_core (
  input  logic          clk,
  input  logic          rst,
  sha_mh_in_if.sink     msg,
  sha_mh_out_if.source  digest
);

  sha_mh_pkg::state_t state, state_next;

  logic [31:0] win [sha_mh_pkg::WINDOW_N];
  logic [31:0] v   [sha_mh_pkg::CHAIN_N];
  logic [3:0]  pos;
  logic [63:0] bit_len;
  logic [5:0]  rc;
  logic [3:0]  seq_cnt;
  logic [2:0]  out_cnt;
  logic [2:0]  rd_idx;
  logic [7:0]  chain_vld;
  logic        padding, need80, hi_done, fin;

  logic [31:0] dg_word;
  logic [2:0]  dg_idx;
  logic        dg_valid;

  // control from the next-state block
  logic        push;
  logic [31:0] push_w;
  logic [5:0]  len_inc;
  logic        len_we, set_pad, set_need80, clr_need80, set_hi, set_fin;
  logic        out_load, done;
  logic [2:0]  raddr;

  // chain-state memory and its read path
  logic        ram_we;
  logic [31:0] ram_wdata, ram_q, chain_rd;

  logic        in_acc;
  logic [2:0]  nb;
  logic [31:0] pad_last;
  logic [31:0] w_t, t1, t2;

  assign in_acc = msg.valid && msg.ready;
  assign msg.ready = (state == sha_mh_pkg::S_IDLE);

  assign digest.valid        = dg_valid;
  assign digest.digest_word  = dg_word;
  assign digest.digest_index = dg_idx;
  assign digest.digest_last  = (dg_idx == 3'd7);

  assign nb = (msg.word_bytes > 3'd4) ? 3'd4 : msg.word_bytes;

  always_comb begin
    case (nb[1:0])
      2'd1:    pad_last = {msg.msg_word[31:24], 24'h80_0000};
      2'd2:    pad_last = {msg.msg_word[31:16], 16'h8000};
      2'd3:    pad_last = {msg.msg_word[31:8], 8'h80};
      default: pad_last = sha_mh_pkg::PAD_WORD;
    endcase
  end

  // entries never written since reset or the last digest read as the initial values
  assign chain_rd = chain_vld[rd_idx] ? ram_q : sha_mh_pkg::IV_TAB[rd_idx];

  assign ram_we    = (state == sha_mh_pkg::S_ADD) && (seq_cnt != 4'd0);
  assign ram_wdata = chain_rd + v[rd_idx];

  sha_mh_ram #(
    .WIDTH (sha_mh_pkg::WORD_W),
    .DEPTH (sha_mh_pkg::CHAIN_N)
  ) u_chain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // round datapath: schedule taps at fixed window positions
  assign w_t = (rc < 6'd16) ? win[0]
             : sha_mh_pkg::ssig1(win[14]) + win[9] + sha_mh_pkg::ssig0(win[1]) + win[0];
  assign t1 = v[7] + sha_mh_pkg::bsig1(v[4]) + sha_mh_pkg::ch_f(v[4], v[5], v[6])
            + sha_mh_pkg::K_TAB[rc] + w_t;
  assign t2 = sha_mh_pkg::bsig0(v[0]) + sha_mh_pkg::maj_f(v[0], v[1], v[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_mh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_w     = '0;
    len_inc    = '0;
    len_we     = 1'b0;
    set_pad    = 1'b0;
    set_need80 = 1'b0;
    clr_need80 = 1'b0;
    set_hi     = 1'b0;
    set_fin    = 1'b0;
    out_load   = 1'b0;
    done       = 1'b0;
    raddr      = seq_cnt[2:0];
    case (state)
      sha_mh_pkg::S_IDLE: begin
        if (in_acc) begin
          push   = 1'b1;
          len_we = 1'b1;
          if (!msg.msg_end) begin
            push_w  = msg.msg_word;
            len_inc = 6'd32;
          end else begin
            len_inc    = {nb, 3'b000};
            set_pad    = 1'b1;
            set_need80 = (nb == 3'd4);
            push_w     = (nb == 3'd4) ? msg.msg_word : pad_last;
          end
          if (pos == 4'd15) begin
            state_next = sha_mh_pkg::S_LOAD;
          end else if (msg.msg_end) begin
            state_next = sha_mh_pkg::S_PAD;
          end
        end
      end
      sha_mh_pkg::S_PAD: begin
        push = 1'b1;
        if (need80) begin
          push_w     = sha_mh_pkg::PAD_WORD;
          clr_need80 = 1'b1;
        end else if (pos == 4'd14) begin
          push_w = bit_len[63:32];
          set_hi = 1'b1;
        end else if (hi_done) begin
          push_w  = bit_len[31:0];
          set_fin = 1'b1;
        end
        if (pos == 4'd15) begin
          state_next = sha_mh_pkg::S_LOAD;
        end
      end
      sha_mh_pkg::S_LOAD: begin
        if (seq_cnt == 4'd8) begin
          state_next = sha_mh_pkg::S_ROUND;
        end
      end
      sha_mh_pkg::S_ROUND: begin
        if (rc == 6'd63) begin
          state_next = sha_mh_pkg::S_ADD;
        end
      end
      sha_mh_pkg::S_ADD: begin
        if (seq_cnt == 4'd8) begin
          if (fin) begin
            state_next = sha_mh_pkg::S_ORD;
          end else if (padding) begin
            state_next = sha_mh_pkg::S_PAD;
          end else begin
            state_next = sha_mh_pkg::S_IDLE;
          end
        end
      end
      sha_mh_pkg::S_ORD: begin
        raddr = out_cnt;
        if (!dg_valid || digest.ready) begin
          state_next = sha_mh_pkg::S_OCAP;
        end
      end
      sha_mh_pkg::S_OCAP: begin
        raddr    = out_cnt;
        out_load = 1'b1;
        state_next = (out_cnt == 3'd7) ? sha_mh_pkg::S_DONE : sha_mh_pkg::S_ORD;
      end
      sha_mh_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = sha_mh_pkg::S_IDLE;
      end
      default: begin
        state_next = sha_mh_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bit_len   <= '0;
      rc        <= '0;
      seq_cnt   <= '0;
      out_cnt   <= '0;
      chain_vld <= '0;
      padding   <= 1'b0;
      need80    <= 1'b0;
      hi_done   <= 1'b0;
      fin       <= 1'b0;
      dg_valid  <= 1'b0;
    end else begin
      if (push) begin
        pos <= pos + 4'd1;
      end
      if (len_we) begin
        bit_len <= bit_len + 64'(len_inc);
      end
      if (set_pad) begin
        padding <= 1'b1;
      end
      if (set_need80) begin
        need80 <= 1'b1;
      end else if (clr_need80) begin
        need80 <= 1'b0;
      end
      if (set_hi) begin
        hi_done <= 1'b1;
      end
      if (set_fin) begin
        fin <= 1'b1;
      end
      if (state == sha_mh_pkg::S_ROUND) begin
        rc <= rc + 6'd1;
      end
      if (state == sha_mh_pkg::S_LOAD || state == sha_mh_pkg::S_ADD) begin
        seq_cnt <= (seq_cnt == 4'd8) ? 4'd0 : seq_cnt + 4'd1;
      end
      if (ram_we) begin
        chain_vld[rd_idx] <= 1'b1;
      end
      if (out_load) begin
        dg_valid <= 1'b1;
        out_cnt  <= out_cnt + 3'd1;
      end else if (digest.ready) begin
        dg_valid <= 1'b0;
      end
      if (done) begin
        chain_vld <= '0;
        bit_len   <= '0;
        padding   <= 1'b0;
        hi_done   <= 1'b0;
        fin       <= 1'b0;
        out_cnt   <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= raddr;
    if (out_load) begin
      dg_word <= chain_rd;
      dg_idx  <= rd_idx;
    end
    if (state == sha_mh_pkg::S_LOAD && seq_cnt != 4'd0) begin
      v[rd_idx] <= chain_rd;
    end
    if (state == sha_mh_pkg::S_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    // window shifts on every pushed word and on every round
    if (push || state == sha_mh_pkg::S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= push ? push_w : w_t;
    end
  end

endmodule

FILE: hdl/sha_mh_checker.sv
// Port-level checker for the SHA-256 core, bound to the top level
`include "sha256_message_hasher_core_defines.svh"

module sha_mh_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_end,
  input logic        dg_valid,
  input logic        dg_ready,
  input logic [31:0] dg_word,
  input logic [2:0]  dg_index,
  input logic        dg_last
);

  // last flag marks exactly the eighth word
  `SMH_ASSERT_NOW(a_last_idx, clk, rst, dg_valid, dg_last == (dg_index == 3'd7))

  // no new message words while a digest is still being read out
  `SMH_ASSERT_NOW(a_no_in_mid_digest, clk, rst, dg_valid && !dg_last, !msg_ready)

  // a final word moves the core to padding or compression, so the input stalls next cycle
  `SMH_ASSERT_NEXT(a_end_stalls, clk, rst, msg_valid && msg_ready && msg_end, !msg_ready)

  // a stalled digest beat holds
  `SMH_ASSERT_NEXT(a_dg_hold, clk, rst, dg_valid && !dg_ready,
                   dg_valid && $stable(dg_word) && $stable(dg_index))

endmodule

bind sha256_message_hasher_core sha_mh_checker u_sha_mh_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg.valid),
  .msg_ready (msg.ready),
  .msg_end   (msg.msg_end),
  .dg_valid  (digest.valid),
  .dg_ready  (digest.ready),
  .dg_word   (digest.digest_word),
  .dg_index  (digest.digest_index),
  .dg_last   (digest.digest_last)
);

FILE: verif/sha256_message_hasher_core_test.sv
// Self-checking testbench for the SHA-256 core: directed and random messages against an in-bench hash model
`timescale 1ns / 100ps

module sha256_message_hasher_core_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned CALM_TAIL = 60;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [2:0] LAST_INDEX = 3'd7;
  localparam logic [31:0] PAD_BYTE = 32'h80;
  localparam int unsigned LEN_HI_SLOT = 14;

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
    logic        hold;   // wait for all digests before offering this beat
  } word_beat_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst;

  sha_mh_in_if  msg_ch ();
  sha_mh_out_if dig_ch ();

  sha256_message_hasher_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  always #6 clk = ~clk;

  // hash model state
  logic [31:0] hash_acc [8];
  logic [31:0] block_buf [16];
  logic [3:0]  fill_pos;
  logic [63:0] msg_bits;

  word_beat_t   word_plan [$];
  digest_beat_t digest_due [$];

  int unsigned words_planned = 0;
  int unsigned words_in = 0;
  int unsigned messages_in = 0;
  int unsigned blocks_hashed = 0;
  int unsigned beats_checked = 0;
  int unsigned n_bad = 0;
  int unsigned cycle = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  logic msg_taken = 1'b0;
  logic calm = 1'b0;
  logic quiet_spell = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void crunch_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
    blocks_hashed++;
  endfunction

  function automatic void append_word(logic [31:0] w);
    block_buf[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) crunch_block();
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_acc[i] = START_HASH[i];
    fill_pos = '0;
    msg_bits = '0;
  endfunction

  // feed one accepted beat; a final word pads, closes and queues the digest
  function automatic void absorb_beat(logic [31:0] word, logic [2:0] nb_in, logic fin);
    int unsigned nb;
    logic [31:0] mask;
    digest_beat_t d;
    if (!fin) begin
      msg_bits = msg_bits + 64'd32;
      append_word(word);
      return;
    end
    nb = (nb_in > 3'd4) ? 4 : nb_in;
    msg_bits = msg_bits + 64'(8 * nb);
    if (nb == 4) begin
      append_word(word);
      append_word(PAD_BYTE << 24);
    end else begin
      mask = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      append_word((word & mask) | (PAD_BYTE << (24 - 8 * nb)));
    end
    while (fill_pos != LEN_HI_SLOT) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.word = hash_acc[i];
      d.idx  = 3'(i);
      d.last = (3'(i) == LAST_INDEX);
      digest_due = {digest_due, d};
    end
    messages_in++;
    restart_hash();
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    n_bad++;
  endtask

  function automatic void plan_word(logic [31:0] word, logic [2:0] nb, logic fin,
                                    logic hold = 1'b0);
    word_beat_t b;
    b.word = word; b.nbytes = nb; b.fin = fin; b.hold = hold;
    word_plan = {word_plan, b};
    words_planned++;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // sample side: predict on accepted words, then check digest beats
  always @(posedge clk) begin
    digest_beat_t e;
    cycle <= cycle + 1;
    if (cycle[7:0] == 8'd0) quiet_spell <= ($urandom_range(0, 2) == 0);
    if (cycle == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("[FAIL] regression broken");
      $finish;
    end
    msg_taken <= !rst && msg_ch.valid && msg_ch.ready;
    if (!rst && msg_ch.valid && msg_ch.ready) begin
      words_in++;
      absorb_beat(msg_ch.msg_word, msg_ch.word_bytes, msg_ch.msg_end);
    end
    if (!rst && dig_ch.valid && dig_ch.ready) begin
      if (digest_due.size() == 0) begin
        report_mismatch($sformatf("digest beat %08h with nothing outstanding",
                                  dig_ch.digest_word));
      end else begin
        e = digest_due.pop_front();
        beats_checked++;
        if (dig_ch.digest_word !== e.word)
          report_mismatch($sformatf("digest_word %08h, want %08h (index %0d)",
                                    dig_ch.digest_word, e.word, e.idx));
        if (dig_ch.digest_index !== e.idx)
          report_mismatch($sformatf("digest_index %0d, want %0d", dig_ch.digest_index, e.idx));
        if (dig_ch.digest_last !== e.last)
          report_mismatch($sformatf("digest_last %0b, want %0b (index %0d)",
                                    dig_ch.digest_last, e.last, e.idx));
      end
    end
  end

  // message driver
  always @(negedge clk) begin
    word_beat_t b;
    if (word_plan.size() < CALM_TAIL) calm <= 1'b1;
    if (rst) begin
      msg_ch.valid <= 1'b0;
    end else if (!msg_ch.valid || msg_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        msg_ch.valid <= 1'b0;
      end else if (word_plan.size() != 0 && (!word_plan[0].hold || digest_due.size() == 0)) begin
        if (!calm && !quiet_spell && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 9);
          msg_ch.valid <= 1'b0;
        end else begin
          b = word_plan.pop_front();
          msg_ch.msg_word   <= b.word;
          msg_ch.word_bytes <= b.nbytes;
          msg_ch.msg_end    <= b.fin;
          msg_ch.valid      <= 1'b1;
        end
      end else begin
        msg_ch.valid <= 1'b0;
      end
    end
  end

  // digest back-pressure
  always @(negedge clk) begin
    if (rst) begin
      dig_ch.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      dig_ch.ready <= 1'b0;
    end else if (!calm && !quiet_spell && $urandom_range(0, 5) == 0) begin
      take_gap <= $urandom_range(0, 9);
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned len;
    logic pause_done;
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.msg_word = '0;
    msg_ch.word_bytes = '0;
    msg_ch.msg_end = 1'b0;
    dig_ch.ready = 1'b0;
    restart_hash();
    pause_done = 1'b0;

    // directed: empty message, short tails, oversize byte count, two-block padding
    plan_word($urandom, 3'd0, 1'b1);
    plan_word(32'h6162_63FF, 3'd3, 1'b1);          // "abc", junk in the dropped byte
    plan_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    plan_word(32'h0000_0000, 3'd2, 1'b1);
    plan_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    plan_word($urandom, 3'd6, 1'b1);               // counts as four bytes
    for (int i = 0; i < 14; i++)
      plan_word((i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFF_FFFF : $urandom,
                3'(i % 8), 1'b0);
    plan_word($urandom, 3'd0, 1'b1);               // padding spills into a second block

    // random messages, mostly short, a few spanning several blocks
    while (words_planned < RANDOM_WORDS + 21) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 40) : $urandom_range(0, 18);
      for (int i = 0; i <= len; i++) begin
        if (i == len)
          plan_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1,
                    len == 0 && !pause_done && words_planned > 21);
        else
          plan_word(pick_word(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                    1'b0, i == 0 && (words_planned == 21 ||
                                     (!pause_done && words_planned > 250)));
        if (word_plan[$].hold && words_planned > 250) pause_done = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (words_in != words_planned) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words in %0d messages, %0d blocks hashed, %0d digest beats checked",
             words_in, messages_in, blocks_hashed, beats_checked);
    $display("tails of 0-7 valid bytes, short words mid-message, one and two padding blocks");
    if (n_bad == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
